// ===== rtl/core/tts_pkg.sv =====
// Shared types, constants and codes for the transport transmit session block.
// No dependencies; every other file in rtl/core except tts_ram imports this package.
package tts_pkg;

  // Payload store geometry: seven byte banks, one packet per row
  localparam int unsigned MAX_BYTES        = 2048;
  localparam int unsigned BYTES_PER_PACKET = 7;
  localparam int unsigned STORE_ROWS       = (MAX_BYTES + BYTES_PER_PACKET - 1) / BYTES_PER_PACKET;
  localparam int unsigned ROW_W            = $clog2(STORE_ROWS);

  // Divide-by-seven via reciprocal, exact for values below 4096
  localparam int unsigned DIV7_MUL   = 4682;
  localparam int unsigned DIV7_SHIFT = 15;

  localparam logic [7:0]  PAD_BYTE     = 8'hFF;
  localparam logic [10:0] LENGTH_LIMIT = 11'd1785;

  // Control bytes
  localparam logic [7:0] CTL_RTS   = 8'd16;
  localparam logic [7:0] CTL_CTS   = 8'd17;
  localparam logic [7:0] CTL_EOM   = 8'd19;
  localparam logic [7:0] CTL_BAM   = 8'd32;
  localparam logic [7:0] CTL_ABORT = 8'd255;

  // Abort codes carried in byte 1 of an abort frame
  localparam logic [7:0] ABT_CODE_TIMEOUT  = 8'd3;
  localparam logic [7:0] ABT_CODE_CONFIRM  = 8'd255;
  localparam logic [7:0] ABT_CODE_MISMATCH = 8'd1;

  typedef enum logic [2:0] {
    FN_LOAD    = 3'd0,
    FN_START   = 3'd1,
    FN_TICK    = 3'd2,
    FN_CONFIRM = 3'd3,
    FN_CONTROL = 3'd4
  } func_e;

  typedef enum logic [2:0] {
    CFG_LENGTH  = 3'd0,
    CFG_GROUP   = 3'd1,
    CFG_BCAST   = 3'd2,
    CFG_GAP     = 3'd3,
    CFG_T3      = 3'd4,
    CFG_T4      = 3'd5,
    CFG_CONFIRM = 3'd6
  } cfg_idx_e;

  // Session phases, one-hot
  typedef enum logic [4:0] {
    PH_IDLE      = 5'b00001,
    PH_SEND_DATA = 5'b00010,
    PH_WAIT_CONF = 5'b00100,
    PH_WAIT_CTS  = 5'b01000,
    PH_WAIT_EOM  = 5'b10000
  } phase_e;

  // Reported session_state codes
  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_SEND_DATA = 3'd3;
  localparam logic [2:0] ST_WAIT_CONF = 3'd4;
  localparam logic [2:0] ST_WAIT_CTS  = 3'd5;
  localparam logic [2:0] ST_WAIT_EOM  = 3'd6;

  typedef enum logic [1:0] {
    KIND_ANNOUNCE = 2'd0,
    KIND_REQUEST  = 2'd1,
    KIND_DATA     = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    RSN_NONE     = 2'd0,
    RSN_TIMEOUT  = 2'd1,
    RSN_CONFIRM  = 2'd2,
    RSN_MISMATCH = 2'd3
  } reason_e;

  // One input word as held in the input register
  typedef struct packed {
    logic [2:0]  func;
    logic [10:0] load_index;
    logic [7:0]  load_byte;
    logic        confirm_ok;
    logic [7:0]  rx_control;
    logic [7:0]  rx_count;
    logic [7:0]  rx_next;
    logic [23:0] rx_group;
  } item_t;

  // One result word
  typedef struct packed {
    logic        frame_send;
    logic        frame_is_data;
    logic        frame_to_global;
    logic [63:0] frame_bytes;
    logic [2:0]  session_state;
    logic [1:0]  abort_reason;
  } result_t;

  // Payload store access from the engine
  typedef struct packed {
    logic        we;
    logic [10:0] windex;
    logic [7:0]  wbyte;
    logic [7:0]  row_a;
    logic [7:0]  row_b;
  } store_req_t;

  function automatic logic [2:0] state_code(phase_e ph);
    logic [2:0] code;
    case (ph)
      PH_IDLE:      code = ST_IDLE;
      PH_SEND_DATA: code = ST_SEND_DATA;
      PH_WAIT_CONF: code = ST_WAIT_CONF;
      PH_WAIT_CTS:  code = ST_WAIT_CTS;
      PH_WAIT_EOM:  code = ST_WAIT_EOM;
      default:      code = ST_IDLE;
    endcase
    return code;
  endfunction

  // x / 7 for x below 3584 (so the quotient fits ROW_W bits), via reciprocal multiply
  function automatic logic [ROW_W-1:0] div7(logic [11:0] x);
    logic [25:0] prod;
    prod = 26'(x) * 26'(DIV7_MUL);
    return ROW_W'(prod >> DIV7_SHIFT);
  endfunction

endpackage

// ===== rtl/core/transport_tx_session.sv =====
// Transmit side of a multi-packet transport session (broadcast announce or
// connection mode with clear-to-send windows). Every input word produces
// exactly one result word. A word accepted into the input register is
// processed combinationally; its result is loaded into the output register
// as the word leaves the input register, so the block takes one word per
// cycle while the output is not stalled. A stall at the output holds the
// result register first and then the input register. Payload bytes sit
// in seven banks of dual-read RAM, one row per packet, so a data frame is
// built from one registered row read. The user must write configuration
// only while no word is in flight; the block itself does not enforce it.
// Depends on tts_pkg, tts_engine, tts_store.
module transport_tx_session (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [23:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  func_i,
  input  logic [10:0] load_index_i,
  input  logic [7:0]  load_byte_i,
  input  logic        confirm_ok_i,
  input  logic [7:0]  rx_control_i,
  input  logic [7:0]  rx_count_i,
  input  logic [7:0]  rx_next_i,
  input  logic [23:0] rx_group_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        frame_send_o,
  output logic        frame_is_data_o,
  output logic        frame_to_global_o,
  output logic [63:0] frame_bytes_o,
  output logic [2:0]  session_state_o,
  output logic [1:0]  abort_reason_o
);
  import tts_pkg::*;

  logic       in_valid_q, out_valid_q;
  item_t      item_q;
  result_t    res_q, res_d;
  logic       advance, fire, in_take;
  store_req_t store_req;
  logic [BYTES_PER_PACKET*8-1:0] row_a, row_b;

  // Handshake: input register drains whenever the output register can load
  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_take || (in_valid_q && !fire);
      out_valid_q <= fire || (out_valid_q && out_stall_i);
    end
  end

  // Input word register
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q <= '{func: func_i, load_index: load_index_i, load_byte: load_byte_i,
                  confirm_ok: confirm_ok_i, rx_control: rx_control_i,
                  rx_count: rx_count_i, rx_next: rx_next_i, rx_group: rx_group_i};
    end
  end

  tts_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .fire_i     (fire),
    .item_i     (item_q),
    .row_a_i    (row_a),
    .row_b_i    (row_b),
    .store_o    (store_req),
    .res_o      (res_d)
  );

  tts_store u_store (
    .clk_i  (clk_i),
    .req_i  (store_req),
    .row_a_o(row_a),
    .row_b_o(row_b)
  );

  // Result register
  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign frame_send_o      = res_q.frame_send;
  assign frame_is_data_o   = res_q.frame_is_data;
  assign frame_to_global_o = res_q.frame_to_global;
  assign frame_bytes_o     = res_q.frame_bytes;
  assign session_state_o   = res_q.session_state;
  assign abort_reason_o    = res_q.abort_reason;

  // A result without a frame carries no frame content
  a_no_frame_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !frame_send_o |-> frame_bytes_o == 64'd0 && abort_reason_o == 2'd0)
    else $error("frame fields set without a frame");

  // An abort always leaves the session idle
  a_abort_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && abort_reason_o != 2'd0 |-> session_state_o == ST_IDLE)
    else $error("abort without going idle");

  // A data frame always leaves the session waiting for confirmation
  a_data_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_is_data_o |-> session_state_o == ST_WAIT_CONF)
    else $error("data frame without waiting for confirmation");

  // A processed word shows up in the output register on the next cycle
  a_fire_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("processed word lost");

endmodule

// ===== rtl/core/tts_ram.sv =====
// Generic RAM: one write port, two registered read ports, write-first.
// No dependencies.
module tts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q, rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Reads see a write to the same address in the same cycle
  always_ff @(posedge clk_i) begin
    rdata_a_q <= (we_i && waddr_i == raddr_a_i) ? wdata_i : mem_q[raddr_a_i];
    rdata_b_q <= (we_i && waddr_i == raddr_b_i) ? wdata_i : mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== rtl/core/tts_store.sv =====
// Payload store: seven byte banks so a whole packet row is read at once.
// Depends on tts_pkg and tts_ram.
module tts_store (
  input  logic                              clk_i,
  input  tts_pkg::store_req_t               req_i,
  output logic [tts_pkg::BYTES_PER_PACKET*8-1:0] row_a_o,
  output logic [tts_pkg::BYTES_PER_PACKET*8-1:0] row_b_o
);
  import tts_pkg::*;

  logic [ROW_W-1:0] wrow;
  logic [ROW_W+2:0] wrow_x7;
  logic [2:0]       wbank;
  logic             in_range;

  // Split byte position into row (index / 7) and bank (index mod 7)
  always_comb begin
    wrow     = div7({1'b0, req_i.windex});
    wrow_x7  = (ROW_W+3)'(wrow) * (ROW_W+3)'(BYTES_PER_PACKET);
    wbank    = 3'(req_i.windex - 11'(wrow_x7));
    in_range = {1'b0, req_i.windex} < 12'(MAX_BYTES);
  end

  for (genvar b = 0; b < BYTES_PER_PACKET; b++) begin : g_bank
    tts_ram #(
      .WIDTH(8),
      .DEPTH(STORE_ROWS)
    ) u_ram (
      .clk_i    (clk_i),
      .we_i     (req_i.we && in_range && wbank == 3'(b)),
      .waddr_i  (wrow),
      .wdata_i  (req_i.wbyte),
      .raddr_a_i(ROW_W'(req_i.row_a)),
      .raddr_b_i(ROW_W'(req_i.row_b)),
      .rdata_a_o(row_a_o[8*b +: 8]),
      .rdata_b_o(row_b_o[8*b +: 8])
    );
  end

endmodule

// ===== rtl/core/tts_engine.sv =====
// Session engine: config registers, session state and one-pass frame build.
// Depends on tts_pkg.
module tts_engine (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [2:0]                        cfg_idx_i,
  input  logic [23:0]                       cfg_wdata_i,
  input  logic                              fire_i,
  input  tts_pkg::item_t                    item_i,
  input  logic [tts_pkg::BYTES_PER_PACKET*8-1:0] row_a_i,
  input  logic [tts_pkg::BYTES_PER_PACKET*8-1:0] row_b_i,
  output tts_pkg::store_req_t               store_o,
  output tts_pkg::result_t                  res_o
);
  import tts_pkg::*;

  // Configuration
  logic [10:0] length_q;
  logic [23:0] group_q;
  logic        bcast_q;
  logic [15:0] gap_q, t3_q, t4_q, climit_q;

  // Session state
  phase_e      phase_q, phase_d;
  kind_e       kind_q, kind_d;
  logic [7:0]  cursor_q, cursor_d;
  logic [8:0]  wend_q, wend_d;
  logic [15:0] elapsed_q, elapsed_d;
  logic [15:0] wlimit_q, wlimit_d;

  logic [8:0]  ptotal;
  logic [10:0] offset;
  logic [BYTES_PER_PACKET*8-1:0] row;
  logic        use_inc, svc;
  logic [7:0]  next_pkt;
  logic [9:0]  win_end;
  result_t     res;

  assign ptotal = 9'(div7(12'(length_q) + 12'd6));
  assign row    = use_inc ? row_b_i : row_a_i;
  assign offset = 11'(cursor_d) * 11'(BYTES_PER_PACKET);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      length_q <= 11'd9;
      group_q  <= '0;
      bcast_q  <= 1'b0;
      gap_q    <= 16'd50;
      t3_q     <= 16'd1250;
      t4_q     <= 16'd1050;
      climit_q <= 16'd1000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LENGTH:  length_q <= cfg_wdata_i[10:0];
        CFG_GROUP:   group_q  <= cfg_wdata_i;
        CFG_BCAST:   bcast_q  <= cfg_wdata_i[0];
        CFG_GAP:     gap_q    <= cfg_wdata_i[15:0];
        CFG_T3:      t3_q     <= cfg_wdata_i[15:0];
        CFG_T4:      t4_q     <= cfg_wdata_i[15:0];
        CFG_CONFIRM: climit_q <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      kind_q    <= KIND_ANNOUNCE;
      cursor_q  <= '0;
      wend_q    <= '0;
      elapsed_q <= '0;
      wlimit_q  <= '0;
    end else if (fire_i) begin
      phase_q   <= phase_d;
      kind_q    <= kind_d;
      cursor_q  <= cursor_d;
      wend_q    <= wend_d;
      elapsed_q <= elapsed_d;
      wlimit_q  <= wlimit_d;
    end
  end

  // Next state and result for the word in the input register
  always_comb begin
    phase_d   = phase_q;
    kind_d    = kind_q;
    cursor_d  = cursor_q;
    wend_d    = wend_q;
    elapsed_d = elapsed_q;
    wlimit_d  = wlimit_q;
    res       = '0;
    use_inc   = 1'b0;
    svc       = 1'b0;
    next_pkt  = item_i.rx_next;
    win_end   = '0;

    if (fire_i) begin
      case (item_i.func)
        FN_START: begin
          if (phase_q == PH_IDLE && length_q != 11'd0 && length_q <= LENGTH_LIMIT) begin
            cursor_d  = '0;
            wend_d    = '0;
            elapsed_d = '0;
            res.frame_send      = 1'b1;
            res.frame_to_global = bcast_q;
            res.frame_bytes = {group_q, PAD_BYTE, 8'(ptotal), 5'd0, length_q[10:8],
                               length_q[7:0], bcast_q ? CTL_BAM : CTL_RTS};
            kind_d  = bcast_q ? KIND_ANNOUNCE : KIND_REQUEST;
            phase_d = PH_WAIT_CONF;
          end
        end
        FN_TICK: begin
          if (elapsed_q != 16'hFFFF) begin
            elapsed_d = elapsed_q + 16'd1;
          end
          if (phase_q == PH_SEND_DATA) begin
            svc = 1'b1;
          end else if (phase_q == PH_WAIT_CTS || phase_q == PH_WAIT_EOM) begin
            if (elapsed_d > wlimit_q) begin
              res.frame_send      = 1'b1;
              res.frame_to_global = bcast_q;
              res.frame_bytes = {group_q, {3{PAD_BYTE}}, ABT_CODE_TIMEOUT, CTL_ABORT};
              res.abort_reason    = RSN_TIMEOUT;
              phase_d = PH_IDLE;
            end
          end else if (phase_q == PH_WAIT_CONF) begin
            if (elapsed_d >= climit_q) begin
              res.frame_send      = 1'b1;
              res.frame_to_global = bcast_q;
              res.frame_bytes = {group_q, {3{PAD_BYTE}}, ABT_CODE_CONFIRM, CTL_ABORT};
              res.abort_reason    = RSN_CONFIRM;
              phase_d = PH_IDLE;
            end
          end
        end
        FN_CONFIRM: begin
          if (phase_q == PH_WAIT_CONF) begin
            if (item_i.confirm_ok) begin
              elapsed_d = '0;
              svc       = 1'b1;
              case (kind_q)
                KIND_ANNOUNCE: begin
                  cursor_d = '0;
                  wend_d   = ptotal;
                  phase_d  = PH_SEND_DATA;
                end
                KIND_REQUEST: begin
                  wlimit_d = t3_q;
                  phase_d  = PH_WAIT_CTS;
                end
                default: begin
                  phase_d  = PH_SEND_DATA;
                  cursor_d = cursor_q + 8'd1;
                  use_inc  = 1'b1;
                  if ({1'b0, cursor_d} >= wend_q) begin
                    if (bcast_q) begin
                      phase_d = PH_IDLE;
                    end else begin
                      wlimit_d = t3_q;
                      phase_d  = ({1'b0, cursor_d} < ptotal) ? PH_WAIT_CTS : PH_WAIT_EOM;
                    end
                  end
                end
              endcase
            end else begin
              phase_d = PH_IDLE;
            end
          end
        end
        FN_CONTROL: begin
          if (phase_q == PH_SEND_DATA) begin
            svc = 1'b1;
          end else if (phase_q == PH_WAIT_CTS || phase_q == PH_WAIT_EOM) begin
            if (item_i.rx_control == CTL_CTS) begin
              if (item_i.rx_group != group_q) begin
                res.frame_send      = 1'b1;
                res.frame_to_global = bcast_q;
                res.frame_bytes = {group_q, {3{PAD_BYTE}}, ABT_CODE_MISMATCH, CTL_ABORT};
                res.abort_reason    = RSN_MISMATCH;
                phase_d = PH_IDLE;
              end else if (item_i.rx_count == 8'd0) begin
                // Receiver stall: restart the wait with the T4 limit
                elapsed_d = '0;
                wlimit_d  = t4_q;
              end else begin
                if (next_pkt == 8'd0) begin
                  next_pkt = 8'd1;
                end
                cursor_d = next_pkt - 8'd1;
                win_end  = 10'(cursor_d) + 10'(item_i.rx_count);
                wend_d   = (win_end > 10'(ptotal)) ? ptotal : 9'(win_end);
                phase_d  = PH_SEND_DATA;
              end
            end else if (item_i.rx_control == CTL_ABORT ||
                         (item_i.rx_control == CTL_EOM && phase_q == PH_WAIT_EOM)) begin
              phase_d = PH_IDLE;
            end
          end
        end
        default: ;
      endcase

      // Data frame for the packet under the cursor, or idle past the end of the payload
      if (svc && phase_d == PH_SEND_DATA && !(bcast_q && elapsed_d < gap_q)) begin
        if (offset >= length_q) begin
          phase_d = PH_IDLE;
        end else begin
          res.frame_send      = 1'b1;
          res.frame_is_data   = 1'b1;
          res.frame_to_global = bcast_q;
          res.frame_bytes[7:0] = cursor_d + 8'd1;
          for (int i = 0; i < BYTES_PER_PACKET; i++) begin
            res.frame_bytes[8*(i+1) +: 8] =
              (offset + 11'(i) >= length_q) ? PAD_BYTE : row[8*i +: 8];
          end
          phase_d   = PH_WAIT_CONF;
          kind_d    = KIND_DATA;
          elapsed_d = '0;
        end
      end
    end

    res.session_state = state_code(phase_d);
  end

  assign res_o = res;

  // Store access: load writes, and reads for the cursor and the one after it
  always_comb begin
    store_o.we     = fire_i && item_i.func == FN_LOAD;
    store_o.windex = item_i.load_index;
    store_o.wbyte  = item_i.load_byte;
    store_o.row_a  = cursor_d;
    store_o.row_b  = cursor_d + 8'd1;
  end

endmodule
